>>> rtl/hight_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hight_pkg;

  // Configuration register indexes
  localparam logic CFG_KEY_LOW  = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  localparam int NUM_ROUNDS = 32;
  localparam int NUM_SK     = 4 * NUM_ROUNDS;

  typedef logic [NUM_SK-1:0][7:0] sk_all_t;
  typedef logic [3:0][7:0]        sk_rnd_t;
  typedef logic [7:0]             delta_tbl_t [NUM_SK];

  // Delta constants: 7-bit LFSR x^7 + x^3 + 1 seeded with 0x5A
  function automatic delta_tbl_t gen_delta();
    delta_tbl_t t;
    logic [6:0] d;
    d = 7'h5A;
    for (int i = 0; i < NUM_SK; i++) begin
      t[i] = {1'b0, d};
      d = {d[3] ^ d[0], d[6:1]};
    end
    return t;
  endfunction

  localparam delta_tbl_t DELTA = gen_delta();

  // Master key byte that feeds subkey idx
  function automatic logic [3:0] sk_src(int idx);
    int grp;
    int pos;
    grp = idx >> 4;
    pos = idx & 15;
    if (pos < 8) begin
      return 4'((pos + 8 - grp) & 7);
    end
    return 4'(((pos - grp) & 7) + 8);
  endfunction

  function automatic logic [7:0] rotl8(logic [7:0] v, int n);
    return 8'((v << n) | (v >> (8 - n)));
  endfunction

  function automatic logic [7:0] hight_f0(logic [7:0] v);
    return rotl8(v, 1) ^ rotl8(v, 2) ^ rotl8(v, 7);
  endfunction

  function automatic logic [7:0] hight_f1(logic [7:0] v);
    return rotl8(v, 3) ^ rotl8(v, 4) ^ rotl8(v, 6);
  endfunction

endpackage

`default_nettype wire

>>> rtl/hight_keysched.sv
`timescale 1ns / 1ps
`default_nettype none

module hight_keysched import hight_pkg::*; (
  input  wire logic [63:0] key_low_i,
  input  wire logic [63:0] key_high_i,
  output sk_all_t          sk_o
);

  logic [127:0] mk;

  assign mk = {key_high_i, key_low_i};

  // Each subkey is one master key byte plus its delta constant
  for (genvar g = 0; g < NUM_SK; g++) begin : g_sk
    localparam logic [3:0] Src = sk_src(g);
    assign sk_o[g] = mk[8*Src +: 8] + DELTA[g];
  end

endmodule

`default_nettype wire

>>> rtl/hight_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module hight_stage import hight_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        adv_i,
  input  wire logic        vld_i,
  input  wire logic [63:0] data_i,
  input  wire sk_rnd_t     sk_i,
  output logic             vld_o,
  output logic [63:0]      data_o
);

  logic [7:0]  x [8];
  logic [63:0] data_d;
  logic [63:0] data_q;
  logic        vld_q;

  // One round, even bytes pass; byte rotation is done in the wiring
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      x[k] = data_i[8*k +: 8];
    end
    data_d = data_i;
    data_d[15:8]  = x[1] + (hight_f1(x[0]) ^ sk_i[0]);
    data_d[31:24] = x[3] ^ (hight_f0(x[2]) + sk_i[1]);
    data_d[47:40] = x[5] + (hight_f1(x[4]) ^ sk_i[2]);
    data_d[63:56] = x[7] ^ (hight_f0(x[6]) + sk_i[3]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

`default_nettype wire

>>> rtl/hight_block_encrypt_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Signals                             | Direction
// ---------+-------------------------------------+----------
// input    | in_valid_i, in_ready_o, plaintext_i | to block
// output   | out_valid_o, out_ready_i, ciphertext_o | from block
// config   | cfg_we_i, cfg_idx_i, cfg_data_i     | to block
//
// One item per cycle unless the output stalls; pipeline: whitening
// register, 32 round stages, final whitening register.
// Reset clears all stage valid bits and both key registers (key = 0).
// A stall at the output freezes the whole pipeline in place; bubbles are
// not squeezed out, nothing is lost or repeated.
module hight_block_encrypt_top import hight_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] plaintext_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      ciphertext_o
);

  logic [63:0] key_low_q;
  logic [63:0] key_high_q;
  logic [127:0] mk;
  sk_all_t     sk;
  logic        adv;

  logic [63:0] wh_d;
  logic [63:0] wh_q;
  logic        wh_vld_q;

  logic [NUM_ROUNDS-1:0][63:0] st_in;
  logic [NUM_ROUNDS-1:0][63:0] st_out;
  logic [NUM_ROUNDS-1:0]       st_vin;
  logic [NUM_ROUNDS-1:0]       st_vout;

  logic [63:0] out_d;
  logic [63:0] out_q;
  logic        out_vld_q;

  // Key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY_LOW:  key_low_q  <= cfg_data_i;
        CFG_KEY_HIGH: key_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign mk = {key_high_q, key_low_q};

  hight_keysched u_keysched (
    .key_low_i  (key_low_q),
    .key_high_i (key_high_q),
    .sk_o       (sk)
  );

  // Whole pipeline moves when the output register is free or drained
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // Initial whitening with key bytes 12..15
  always_comb begin
    wh_d = plaintext_i;
    wh_d[7:0]   = plaintext_i[7:0]   + mk[103:96];
    wh_d[23:16] = plaintext_i[23:16] ^ mk[111:104];
    wh_d[39:32] = plaintext_i[39:32] + mk[119:112];
    wh_d[55:48] = plaintext_i[55:48] ^ mk[127:120];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wh_vld_q <= 1'b0;
    end else if (adv) begin
      wh_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wh_q <= wh_d;
    end
  end

  // Round stages; byte rotation between stages, none after the last
  for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_rnd
    if (r == 0) begin : g_first
      assign st_in[r]  = wh_q;
      assign st_vin[r] = wh_vld_q;
    end else begin : g_next
      assign st_in[r]  = {st_out[r-1][55:0], st_out[r-1][63:56]};
      assign st_vin[r] = st_vout[r-1];
    end

    hight_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .vld_i  (st_vin[r]),
      .data_i (st_in[r]),
      .sk_i   (sk[4*r+3 : 4*r]),
      .vld_o  (st_vout[r]),
      .data_o (st_out[r])
    );
  end

  // Final whitening with key bytes 0..3
  always_comb begin
    out_d = st_out[NUM_ROUNDS-1];
    out_d[7:0]   = st_out[NUM_ROUNDS-1][7:0]   + mk[7:0];
    out_d[23:16] = st_out[NUM_ROUNDS-1][23:16] ^ mk[15:8];
    out_d[39:32] = st_out[NUM_ROUNDS-1][39:32] + mk[23:16];
    out_d[55:48] = st_out[NUM_ROUNDS-1][55:48] ^ mk[31:24];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= st_vout[NUM_ROUNDS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign ciphertext_o = out_q;

endmodule

`default_nettype wire
